@@ design/wprm_pkg.sv @@
// Shared types and constants of the windowed packet rate meter.
`default_nettype none
package wprm_pkg;

  localparam int NumStreamsDef   = 8;
  localparam int RingDepthDef    = 256;
  localparam int RateFracBitsDef = 16;

  localparam int SidW    = 3;
  localparam int TsW     = 63;
  localparam int WinW    = 27;
  localparam int ActW    = 4;
  localparam int RateW   = 48;
  localparam int UsecW   = 20;
  localparam int CfgIdxW = 1;

  localparam logic [UsecW-1:0] UsecPerSec    = 20'd1000000;
  localparam logic [WinW-1:0]  MaxWindowUsec = 27'd100000000;
  localparam logic [WinW-1:0]  WindowReset   = 27'd3000000;
  localparam logic [ActW-1:0]  ActiveReset   = 4'd1;
  localparam logic [RateW-1:0] RateMax       = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_STREAM  = 2'd1,
    ERR_ELAPSED = 2'd2
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW = 1'd0,
    CFG_ACTIVE = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic load_in;
    logic setup;
    logic ev_step;
    logic fin;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic evict;
    logic seen;
    logic denom_zero;
    logic div_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ design/wprm_ctrl.sv @@
// Controller state machine of the packet rate meter.
`default_nettype none
module wprm_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wprm_pkg::status_t   status_i,
  output wprm_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_EVRD  = 3'd2;
  localparam logic [2:0] S_EVCHK = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        if (status_i.valid) begin
          cmd_o.setup = 1'b1;
          state_d = S_EVRD;
        end else begin
          state_d = S_DONE;
        end
      end
      // wait for the head entry to come out of the ring memory
      S_EVRD: state_d = S_EVCHK;
      S_EVCHK: begin
        if (status_i.evict) begin
          cmd_o.ev_step = 1'b1;
          state_d = S_EVRD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        if (status_i.seen && !status_i.denom_zero) state_d = S_DIV;
        else state_d = S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

@@ design/wprm_dp.sv @@
// Datapath of the packet rate meter: stream state, timestamp ring, divider, output word.
`default_nettype none
module wprm_dp #(
  parameter int NUM_STREAMS    = wprm_pkg::NumStreamsDef,
  parameter int RING_DEPTH     = wprm_pkg::RingDepthDef,
  parameter int RATE_FRAC_BITS = wprm_pkg::RateFracBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [wprm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [wprm_pkg::WinW-1:0]     cfg_data_i,
  input  wire [wprm_pkg::SidW-1:0]     in_sid_i,
  input  wire [wprm_pkg::TsW-1:0]      in_ts_i,
  input  wprm_pkg::cmd_t               cmd_i,
  output wprm_pkg::status_t            status_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [wprm_pkg::SidW-1:0]    out_stream_o,
  output logic [wprm_pkg::TsW-1:0]     out_ts_o,
  output logic [wprm_pkg::RateW-1:0]   out_rate_o,
  output logic                         out_first_o,
  output logic                         out_ovf_o,
  output logic [1:0]                   out_err_o
);

  localparam int SIDX_W    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int HEAD_W    = $clog2(RING_DEPTH);
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_STREAMS * RING_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int PROD_W    = CNT_W + wprm_pkg::UsecW;
  localparam int NUM_W     = PROD_W + RATE_FRAC_BITS;
  localparam int REM_W     = wprm_pkg::WinW + 1;
  localparam int DCNT_W    = $clog2(NUM_W);
  localparam int MAXW      = (NUM_W > wprm_pkg::RateW) ? NUM_W : wprm_pkg::RateW;
  localparam int LIM_W     = 7;
  localparam int TsW       = wprm_pkg::TsW;
  localparam int WinW      = wprm_pkg::WinW;

  function automatic logic [HEAD_W-1:0] wrap(input logic [HEAD_W:0] p);
    if (p >= (HEAD_W+1)'(RING_DEPTH)) wrap = HEAD_W'(p - (HEAD_W+1)'(RING_DEPTH));
    else wrap = HEAD_W'(p);
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [SIDX_W-1:0] s,
                                                  input logic [HEAD_W-1:0] pos);
    ring_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(RING_DEPTH)) + ADDR_W'(pos);
  endfunction

  // configuration
  logic [WinW-1:0]           window_q;
  logic [wprm_pkg::ActW-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= wprm_pkg::WindowReset;
      active_q <= wprm_pkg::ActiveReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wprm_pkg::CFG_WINDOW: window_q <= cfg_data_i;
        wprm_pkg::CFG_ACTIVE: active_q <= cfg_data_i[wprm_pkg::ActW-1:0];
        default: ;
      endcase
    end
  end

  logic [WinW-1:0] win;
  assign win = (window_q > wprm_pkg::MaxWindowUsec) ? wprm_pkg::MaxWindowUsec : window_q;

  // per-stream state
  logic [HEAD_W-1:0] head_r  [NUM_STREAMS];
  logic [CNT_W-1:0]  cnt_r   [NUM_STREAMS];
  logic              seen_r  [NUM_STREAMS];
  logic [TsW-1:0]    first_r [NUM_STREAMS];

  // working registers of the word in flight
  logic [wprm_pkg::SidW-1:0] sid_q;
  logic [SIDX_W-1:0]         sidx_q;
  logic [TsW-1:0]            now_q;
  logic                      valid_q;
  logic [HEAD_W-1:0]         head_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      ovf_q;
  logic                      first_q;
  wprm_pkg::err_e            err_q;
  logic [NUM_W-1:0]          num_q;
  logic [WinW-1:0]           den_q;
  logic [REM_W-1:0]          rem_q;
  logic [DCNT_W-1:0]         dcnt_q;
  logic [TsW-1:0]            rd_q;

  logic [LIM_W-1:0] lim, act_ext;
  assign act_ext = LIM_W'(active_q);
  assign lim = (act_ext < LIM_W'(NUM_STREAMS)) ? act_ext : LIM_W'(NUM_STREAMS);

  // append: make room when full, then write behind the tail
  logic [HEAD_W-1:0] head_s, head_w, cnt_w, wpos;
  logic [CNT_W-1:0]  cnt_s;
  logic              full;

  always_comb begin
    head_s = head_r[sidx_q];
    cnt_s  = cnt_r[sidx_q];
    full   = (cnt_s == CNT_W'(RING_DEPTH));
    head_w = full ? wrap({1'b0, head_s} + (HEAD_W+1)'(1)) : head_s;
    cnt_w  = full ? HEAD_W'(RING_DEPTH - 1) : HEAD_W'(cnt_s);
    wpos   = wrap({1'b0, head_w} + {1'b0, cnt_w});
  end

  logic [TsW-1:0]  elapsed;
  logic [WinW-1:0] denom;
  logic [PROD_W-1:0] prod;

  always_comb begin
    elapsed = (now_q >= first_r[sidx_q]) ? now_q - first_r[sidx_q] : '0;
    denom   = (elapsed < TsW'(win)) ? elapsed[WinW-1:0] : win;
    prod    = PROD_W'(cnt_q) * PROD_W'(wprm_pkg::UsecPerSec);
  end

  logic [REM_W-1:0] trial;
  logic             ge;
  assign trial = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    status_o.valid      = valid_q;
    status_o.evict      = (cnt_q != '0) && (now_q >= rd_q) && ((now_q - rd_q) > TsW'(win));
    status_o.seen       = seen_r[sidx_q];
    status_o.denom_zero = (denom == '0);
    status_o.div_last   = (dcnt_q == DCNT_W'(NUM_W - 1));
    status_o.out_free   = !out_valid_o || out_ready_i;
  end

  // ring memory: one write, one registered read at the head
  logic [TsW-1:0] ring_mem [MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) ring_mem[ring_addr(sidx_q, wpos)] <= now_q;
    rd_q <= ring_mem[ring_addr(sidx_q, head_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
        seen_r[i] <= 1'b0;
      end
    end else if (cmd_i.fin) begin
      head_r[sidx_q] <= head_q;
      cnt_r[sidx_q]  <= cnt_q;
      seen_r[sidx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin && !seen_r[sidx_q]) first_r[sidx_q] <= now_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sid_q   <= in_sid_i;
      sidx_q  <= SIDX_W'(in_sid_i);
      now_q   <= in_ts_i;
      valid_q <= (LIM_W'(in_sid_i) < lim);
      err_q   <= (LIM_W'(in_sid_i) < lim) ? wprm_pkg::ERR_OK : wprm_pkg::ERR_STREAM;
      ovf_q   <= 1'b0;
      first_q <= 1'b0;
      num_q   <= '0;
    end
    if (cmd_i.setup) begin
      head_q <= head_w;
      cnt_q  <= CNT_W'(cnt_w) + CNT_W'(1);
      ovf_q  <= full;
    end
    if (cmd_i.ev_step) begin
      // drop the head entry
      head_q <= wrap({1'b0, head_q} + (HEAD_W+1)'(1));
      cnt_q  <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.fin) begin
      if (!seen_r[sidx_q]) begin
        first_q <= 1'b1;
      end else if (denom == '0) begin
        err_q <= wprm_pkg::ERR_ELAPSED;
      end else begin
        den_q  <= denom;
        num_q  <= NUM_W'(prod) << RATE_FRAC_BITS;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      // restoring divide, quotient bits shift in where numerator bits leave
      rem_q  <= ge ? trial - {1'b0, den_q} : trial;
      num_q  <= {num_q[NUM_W-2:0], ge};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
  end

  // output word register
  logic [MAXW-1:0] quo;
  assign quo = MAXW'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.out_load) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_stream_o <= sid_q;
      out_ts_o     <= now_q;
      out_rate_o   <= (quo > MAXW'(wprm_pkg::RateMax)) ? wprm_pkg::RateMax
                                                       : wprm_pkg::RateW'(quo);
      out_first_o  <= first_q;
      out_ovf_o    <= ovf_q;
      out_err_o    <= err_q;
    end
  end

endmodule
`default_nettype wire

@@ design/windowed_packet_rate_meter.sv @@
// Each input word runs setup, an evict step per expired ring entry, a finish step and,
// for a seen stream with nonzero elapsed time, a divider of NUM_W quotient bits, where
// NUM_W = clog2(depth+1) + 20 + frac bits (45 at defaults); a bad stream skips to the end.
// One packet at a time: the next word is taken after the last enters the output register,
// where it waits while the next packet runs; a full output register not being read stalls.
// Reset (async, active low) clears stream heads, counts and seen flags; ring is garbage.
`default_nettype none
module windowed_packet_rate_meter #(
  parameter int NUM_STREAMS    = wprm_pkg::NumStreamsDef,
  parameter int RING_DEPTH     = wprm_pkg::RingDepthDef,
  parameter int RATE_FRAC_BITS = wprm_pkg::RateFracBitsDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [wprm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire [wprm_pkg::WinW-1:0]    cfg_data_i,
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // stream[2:0], timestamp[65:3], zero pad [71:66]
  input  wire [71:0]                  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire                         m_axis_tready_i,
  // out_stream[2:0], out_timestamp[65:3], rate_hz[113:66], first_packet[114],
  // overflow[115], error[117:116], zero pad [119:118]
  output logic [119:0]                m_axis_tdata_o
);

  wprm_pkg::cmd_t    cmd;
  wprm_pkg::status_t status;

  logic [wprm_pkg::SidW-1:0]  out_stream;
  logic [wprm_pkg::TsW-1:0]   out_ts;
  logic [wprm_pkg::RateW-1:0] out_rate;
  logic                       out_first, out_ovf;
  logic [1:0]                 out_err;

  wprm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wprm_dp #(
    .NUM_STREAMS    (NUM_STREAMS),
    .RING_DEPTH     (RING_DEPTH),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_sid_i     (s_axis_tdata_i[2:0]),
    .in_ts_i      (s_axis_tdata_i[65:3]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_stream_o (out_stream),
    .out_ts_o     (out_ts),
    .out_rate_o   (out_rate),
    .out_first_o  (out_first),
    .out_ovf_o    (out_ovf),
    .out_err_o    (out_err)
  );

  assign m_axis_tdata_o = {2'b00, out_err, out_ovf, out_first, out_rate, out_ts, out_stream};

endmodule
`default_nettype wire
